### rtl/smf_track_event_parser_macros.svh
// Assertion helpers for the checker file.
`ifndef SMF_TRACK_EVENT_PARSER_MACROS_SVH
`define SMF_TRACK_EVENT_PARSER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SMF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("smf checker: implication failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("smf checker: next-cycle implication failed");

`endif

### rtl/smf_pkg.sv
package smf_pkg;

    // Result kinds, carried on m_axis_tuser
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_HEADER    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CHANNEL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_META      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_META_DATA = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd4;

    // Error codes
    localparam int ERR_W = 4;
    localparam logic [ERR_W-1:0] ERR_NONE       = 4'd0;
    localparam logic [ERR_W-1:0] ERR_SIGNATURE  = 4'd1;
    localparam logic [ERR_W-1:0] ERR_LENGTH     = 4'd2;
    localparam logic [ERR_W-1:0] ERR_FORMAT     = 4'd3;
    localparam logic [ERR_W-1:0] ERR_TRACKS     = 4'd4;
    localparam logic [ERR_W-1:0] ERR_DIVISION   = 4'd5;
    localparam logic [ERR_W-1:0] ERR_TRK_SIG    = 4'd6;
    localparam logic [ERR_W-1:0] ERR_STATUS     = 4'd7;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED  = 4'd8;

    // Chunk signatures and header constants
    localparam logic [31:0] SIG_MTHD    = 32'h4D54_6864;
    localparam logic [31:0] SIG_MTRK    = 32'h4D54_726B;
    localparam logic [31:0] HDR_LEN     = 32'd6;
    localparam logic [15:0] ONE_TRACK   = 16'd1;

    // Status byte values
    localparam logic [7:0] STATUS_META = 8'hFF;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;
    localparam logic [3:0] NIB_PRESSURE = 4'hD;
    localparam logic [3:0] NIB_SYSTEM   = 4'hF;

    // Field widths
    localparam int TICK_W = 32;
    localparam int VLQ_W  = 28;
    localparam int WORD_W = 16;

    // Result tdata layout, lowest bit first
    localparam int OFS_ERR    = 0;
    localparam int OFS_TICK   = OFS_ERR + ERR_W;
    localparam int OFS_NIB    = OFS_TICK + TICK_W;
    localparam int OFS_CHAN   = OFS_NIB + 4;
    localparam int OFS_DATA1  = OFS_CHAN + 4;
    localparam int OFS_DATA2  = OFS_DATA1 + 8;
    localparam int OFS_MLEN   = OFS_DATA2 + 8;
    localparam int OFS_FMT    = OFS_MLEN + VLQ_W;
    localparam int OFS_TRK    = OFS_FMT + WORD_W;
    localparam int OFS_DIV    = OFS_TRK + WORD_W;
    localparam int FIELDS_W   = OFS_DIV + WORD_W;
    localparam int TDATA_W    = ((FIELDS_W + 7) / 8) * 8;

endpackage

### rtl/smf_track_event_parser.sv
// A byte's result enters the result register at the edge that transfers the byte.
// Throughput: one file byte per cycle unless a stalled result blocks the input; the parser
// state updates in a single pass between the input transfer and the result register, which holds one result.
// Reset: aresetn is synchronous, active low; it returns the parser to the MThd check,
// clears the tick, the counters and the halt flag, and empties the result register.
module smf_track_event_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // data_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // error_code, tick, status_nibble, channel, data1, data2, meta_length,
    // header_format, header_tracks, header_division
    output logic [smf_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [smf_pkg::KIND_W-1:0]  m_axis_tuser,  // kind
    output logic                        m_axis_tlast   // track_end
);
    import smf_pkg::*;

    // Parser phases, one-hot
    typedef enum logic [14:0] {
        PH_SIG_HDR   = 15'h0001,
        PH_HDR_LEN   = 15'h0002,
        PH_FORMAT    = 15'h0004,
        PH_TRACKS    = 15'h0008,
        PH_DIV       = 15'h0010,
        PH_SIG_TRK   = 15'h0020,
        PH_TRK_LEN   = 15'h0040,
        PH_DELTA     = 15'h0080,
        PH_STATUS    = 15'h0100,
        PH_DATA1     = 15'h0200,
        PH_DATA2     = 15'h0400,
        PH_META_TYPE = 15'h0800,
        PH_META_LEN  = 15'h1000,
        PH_META_DATA = 15'h2000,
        PH_DONE      = 15'h4000
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        logic [3:0]        nib;
        logic [3:0]        chan;
        logic [7:0]        data1;
        logic [7:0]        data2;
        logic [VLQ_W-1:0]  mlen;
        logic [WORD_W-1:0] div;
        logic              last;
    } result_t;

    // Parser state
    phase_t              phase_reg,     phase_next;
    logic [2:0]          pos_reg,       pos_next;
    logic [31:0]         shift_reg,     shift_next;
    logic [WORD_W-1:0]   format_reg,    format_next;
    logic [WORD_W-1:0]   tracks_reg,    tracks_next;
    logic [TICK_W-1:0]   tick_reg,      tick_next;
    logic [VLQ_W-1:0]    vlq_reg,       vlq_next;
    logic [7:0]          status_reg,    status_next;
    logic [7:0]          first_reg,     first_next;
    logic [VLQ_W-1:0]    meta_rem_reg,  meta_rem_next;
    logic [31:0]         trk_rem_reg,   trk_rem_next;
    logic                halted_reg,    halted_next;

    // Result register
    logic                    out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]      out_data_reg,  out_data_next;
    logic [KIND_W-1:0]       out_kind_reg,  out_kind_next;
    logic                    out_last_reg,  out_last_next;

    logic               accept;
    logic               res_valid;
    result_t            res;
    logic [7:0]         b;
    logic [2:0]         pos_inc;
    logic [2:0]         field_len;
    logic [31:0]        shift_in;
    logic [VLQ_W-1:0]   vlq_in;
    logic [31:0]        trk_dec;
    logic [VLQ_W-1:0]   meta_dec;
    logic               complete;
    logic               failed;
    logic [3:0]         nib;

    // The result register frees up in the same cycle it is read out.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    assign pos_inc  = pos_reg + 3'd1;
    assign shift_in = {shift_reg[23:0], b};
    assign vlq_in   = {vlq_reg[VLQ_W-8:0], b[6:0]};
    assign trk_dec  = trk_rem_reg - 32'd1;
    assign meta_dec = meta_rem_reg - {{(VLQ_W-1){1'b0}}, 1'b1};
    assign nib      = b[7:4];
    assign field_len = (phase_reg == PH_FORMAT || phase_reg == PH_TRACKS ||
                        phase_reg == PH_DIV) ? 3'd2 : 3'd4;

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        format_next   = format_reg;
        tracks_next   = tracks_reg;
        tick_next     = tick_reg;
        vlq_next      = vlq_reg;
        status_next   = status_reg;
        first_next    = first_reg;
        meta_rem_next = meta_rem_reg;
        trk_rem_next  = trk_rem_reg;
        halted_next   = halted_reg;
        res_valid     = 1'b0;
        res           = '0;
        complete      = 1'b0;
        failed        = 1'b0;

        if (!halted_reg && phase_reg != PH_DONE) begin
            if (phase_reg == PH_SIG_HDR || phase_reg == PH_HDR_LEN ||
                phase_reg == PH_FORMAT  || phase_reg == PH_TRACKS  ||
                phase_reg == PH_DIV     || phase_reg == PH_SIG_TRK ||
                phase_reg == PH_TRK_LEN) begin
                // Header chunk and track chunk header: gather big-endian fields
                shift_next = shift_in;
                if (pos_inc != field_len) begin
                    pos_next = pos_inc;
                end else begin
                    pos_next = '0;
                    unique case (phase_reg)
                        PH_SIG_HDR: begin
                            if (shift_in != SIG_MTHD) begin
                                failed   = 1'b1;
                                res.err  = ERR_SIGNATURE;
                            end else begin
                                phase_next = PH_HDR_LEN;
                            end
                        end
                        PH_HDR_LEN: begin
                            if (shift_in != HDR_LEN) begin
                                failed   = 1'b1;
                                res.err  = ERR_LENGTH;
                            end else begin
                                phase_next = PH_FORMAT;
                            end
                        end
                        PH_FORMAT: begin
                            format_next = shift_in[WORD_W-1:0];
                            phase_next  = PH_TRACKS;
                        end
                        PH_TRACKS: begin
                            tracks_next = shift_in[WORD_W-1:0];
                            phase_next  = PH_DIV;
                        end
                        PH_DIV: begin
                            // Check order: format, tracks, division
                            res.div = shift_in[WORD_W-1:0];
                            if (format_reg != '0) begin
                                failed  = 1'b1;
                                res.err = ERR_FORMAT;
                            end else if (tracks_reg != ONE_TRACK) begin
                                failed  = 1'b1;
                                res.err = ERR_TRACKS;
                            end else if (shift_in[WORD_W-1]) begin
                                failed  = 1'b1;
                                res.err = ERR_DIVISION;
                            end else begin
                                phase_next = PH_SIG_TRK;
                                res_valid  = 1'b1;
                                res.kind   = KIND_HEADER;
                            end
                        end
                        PH_SIG_TRK: begin
                            if (shift_in != SIG_MTRK) begin
                                failed  = 1'b1;
                                res.err = ERR_TRK_SIG;
                            end else begin
                                phase_next = PH_TRK_LEN;
                            end
                        end
                        default: begin
                            // Track length; an empty track ends parsing silently
                            trk_rem_next = shift_in;
                            vlq_next     = '0;
                            phase_next   = (shift_in == '0) ? PH_DONE : PH_DELTA;
                        end
                    endcase
                end
            end else begin
                // Track body: every byte counts against the track length
                trk_rem_next = trk_dec;
                unique case (phase_reg)
                    PH_DELTA: begin
                        vlq_next = vlq_in;
                        if (!b[7]) begin
                            tick_next  = tick_reg + {{(TICK_W-VLQ_W){1'b0}}, vlq_in};
                            phase_next = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        if (b == STATUS_META) begin
                            phase_next = PH_META_TYPE;
                        end else if (nib < NIB_NOTE_OFF || nib == NIB_SYSTEM) begin
                            // Running status and system messages are not handled
                            failed  = 1'b1;
                            res.err = ERR_STATUS;
                        end else begin
                            status_next = b;
                            phase_next  = PH_DATA1;
                        end
                    end
                    PH_DATA1: begin
                        first_next = b;
                        if (status_reg[7:4] == NIB_PROGRAM ||
                            status_reg[7:4] == NIB_PRESSURE) begin
                            res_valid = 1'b1;
                            res.kind  = KIND_CHANNEL;
                            res.nib   = status_reg[7:4];
                            res.chan  = status_reg[3:0];
                            res.data1 = b;
                            complete  = 1'b1;
                        end else begin
                            phase_next = PH_DATA2;
                        end
                    end
                    PH_DATA2: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_CHANNEL;
                        res.nib   = status_reg[7:4];
                        res.chan  = status_reg[3:0];
                        res.data1 = first_reg;
                        res.data2 = b;
                        complete  = 1'b1;
                    end
                    PH_META_TYPE: begin
                        first_next = b;
                        vlq_next   = '0;
                        phase_next = PH_META_LEN;
                    end
                    PH_META_LEN: begin
                        vlq_next = vlq_in;
                        if (!b[7]) begin
                            meta_rem_next = vlq_in;
                            res_valid     = 1'b1;
                            res.kind      = KIND_META;
                            res.data1     = first_reg;
                            res.mlen      = vlq_in;
                            if (vlq_in == '0) begin
                                complete = 1'b1;
                            end else begin
                                phase_next = PH_META_DATA;
                            end
                        end
                    end
                    PH_META_DATA: begin
                        res_valid     = 1'b1;
                        res.kind      = KIND_META_DATA;
                        res.data1     = b;
                        meta_rem_next = meta_dec;
                        complete      = (meta_dec == '0);
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase

                // Track ran out in the middle of an event
                if (!failed && trk_dec == '0 && !complete) begin
                    failed  = 1'b1;
                    res     = '0;
                    res.err = ERR_TRUNCATED;
                end
                if (!failed && complete) begin
                    vlq_next = '0;
                    if (trk_dec == '0) begin
                        res.last   = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_DELTA;
                    end
                end
            end

            if (failed) begin
                // Error result keeps only the code and, for the format, tracks and division checks, the division
                halted_next = 1'b1;
                res_valid   = 1'b1;
                res.kind    = KIND_ERROR;
                res.nib     = '0;
                res.chan    = '0;
                res.data1   = '0;
                res.data2   = '0;
                res.mlen    = '0;
                res.last    = 1'b0;
            end
        end
    end

    // Result register: load on a producing transfer, drop once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept && res_valid) begin
            out_valid_next = 1'b1;
            out_kind_next  = res.kind;
            out_last_next  = res.last;
            out_data_next  = '0;
            out_data_next[OFS_ERR  +: ERR_W]  = res.err;
            out_data_next[OFS_TICK +: TICK_W] = tick_next;
            out_data_next[OFS_NIB  +: 4]      = res.nib;
            out_data_next[OFS_CHAN +: 4]      = res.chan;
            out_data_next[OFS_DATA1 +: 8]     = res.data1;
            out_data_next[OFS_DATA2 +: 8]     = res.data2;
            out_data_next[OFS_MLEN +: VLQ_W]  = res.mlen;
            out_data_next[OFS_FMT  +: WORD_W] = format_next;
            out_data_next[OFS_TRK  +: WORD_W] = tracks_next;
            out_data_next[OFS_DIV  +: WORD_W] = res.div;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SIG_HDR;
            pos_reg       <= '0;
            shift_reg     <= '0;
            format_reg    <= '0;
            tracks_reg    <= '0;
            tick_reg      <= '0;
            vlq_reg       <= '0;
            status_reg    <= '0;
            first_reg     <= '0;
            meta_rem_reg  <= '0;
            trk_rem_reg   <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                shift_reg    <= shift_next;
                format_reg   <= format_next;
                tracks_reg   <= tracks_next;
                tick_reg     <= tick_next;
                vlq_reg      <= vlq_next;
                status_reg   <= status_next;
                first_reg    <= first_next;
                meta_rem_reg <= meta_rem_next;
                trk_rem_reg  <= trk_rem_next;
                halted_reg   <= halted_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### rtl/smf_track_event_parser_checker.sv
`include "smf_track_event_parser_macros.svh"

module smf_track_event_parser_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [smf_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic [smf_pkg::KIND_W-1:0]  m_axis_tuser,
    input logic                        m_axis_tlast
);
    import smf_pkg::*;

    // A stalled result holds
    `SMF_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Nothing follows an error result
    `SMF_ASSERT_NEXT(a_halt_after_error, m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_ERROR, !m_axis_tvalid)

    // Only error results carry an error code
    `SMF_ASSERT_IMP(a_code_only_on_error, m_axis_tvalid && m_axis_tuser != KIND_ERROR, m_axis_tdata[OFS_ERR +: ERR_W] == ERR_NONE)

    // Track end comes only with an event result
    `SMF_ASSERT_IMP(a_last_on_event, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KIND_CHANNEL || m_axis_tuser == KIND_META || m_axis_tuser == KIND_META_DATA)

    // No result appears without an input transfer
    `SMF_ASSERT_NEXT(a_no_result_without_input, !s_axis_tvalid && !m_axis_tvalid, !m_axis_tvalid)

    // Input is open whenever the result register is empty
    `SMF_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

endmodule

bind smf_track_event_parser smf_track_event_parser_checker u_checker (.*);
